// ===== design/appliance_timed_action_sequencer_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef APPLIANCE_TIMED_ACTION_SEQUENCER_UNIT_DEFINES_SVH
`define APPLIANCE_TIMED_ACTION_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ATS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ATS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ats_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ats_pkg;

  localparam int unsigned MS_PER_SECOND_DEFAULT = 1000;
  localparam int unsigned SECS_PER_MIN = 60;

  localparam int unsigned CFG_W = 12;
  localparam int unsigned TIMER_W = 14;
  localparam int unsigned ACC_W = 17;

  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  localparam logic [CFG_W-1:0] SOAP_SECONDS_RST = 12'd30;
  localparam logic [CFG_W-1:0] FILL_MAX_SECONDS_RST = 12'd300;
  localparam logic [CFG_W-1:0] EMPTY_SECONDS_RST = 12'd120;
  localparam logic [CFG_W-1:0] INITIAL_FILL_SECONDS_RST = 12'd120;

  localparam int unsigned RLY_SOAP = 0;
  localparam int unsigned RLY_VALVE = 1;
  localparam int unsigned RLY_WASH = 2;
  localparam int unsigned RLY_PUMP = 3;

  typedef enum logic [1:0] {
    CFG_SOAP_SECONDS = 2'd0,
    CFG_FILL_MAX_SECONDS = 2'd1,
    CFG_EMPTY_SECONDS = 2'd2,
    CFG_INITIAL_FILL_SECONDS = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_SOAP = 2'd0,
    KIND_FILL = 2'd1,
    KIND_WASH = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ACT_NONE = 3'd0,
    ACT_SOAP = 3'd1,
    ACT_FILL = 3'd2,
    ACT_WASH = 3'd3,
    ACT_EMPTY = 3'd4
  } action_t;

  typedef struct packed {
    logic [CFG_W-1:0] soap_seconds;
    logic [CFG_W-1:0] fill_max_seconds;
    logic [CFG_W-1:0] empty_seconds;
    logic [CFG_W-1:0] initial_fill_seconds;
  } ats_cfg_t;

  typedef struct packed {
    kind_t kind;
    logic [7:0] wash_minutes;
    logic door_open;
    logic water_full;
    logic [15:0] elapsed_ms;
  } ats_item_t;

  typedef struct packed {
    action_t action;
    logic [TIMER_W-1:0] timer;
    logic [CFG_W-1:0] budget;
    logic [CFG_W-1:0] learned;
    logic [ACC_W-1:0] acc;
    logic [3:0] relays;
    logic error;
    logic fill_done;
  } ats_state_t;

endpackage

`default_nettype wire

// ===== design/appliance_timed_action_sequencer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake             Payload
// input     in_valid / in_ready   kind, wash_minutes, door_open, water_full, elapsed_ms
// result    out_valid / out_ready remaining_seconds, active_action, relays, fill_error
// config    cfg_we                cfg_index, cfg_data
//
// One request per cycle while the result is not stalled: a request is latched in the input
// register, and when the result register is free one pass of the step logic updates the
// state, which drives the result ports.
// Reset clears the state and loads the register defaults.
// A stalled result holds the step logic, and the input register then holds one more.

module appliance_timed_action_sequencer_unit
  import ats_pkg::*;
#(
  parameter int unsigned MS_PER_SECOND = MS_PER_SECOND_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         kind,
  input  wire logic [7:0]         wash_minutes,
  input  wire logic               door_open,
  input  wire logic               water_full,
  input  wire logic [15:0]        elapsed_ms,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [TIMER_W-1:0]      remaining_seconds,
  output logic [2:0]              active_action,
  output logic                    soap_relay,
  output logic                    valve_relay,
  output logic                    wash_relay,
  output logic                    pump_relay,
  output logic                    fill_error
);

  ats_cfg_t   cfg;
  ats_item_t  item;
  logic       item_valid;
  ats_state_t st;
  ats_state_t st_next;
  logic       fire;

  ats_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ats_step_logic #(
    .MS_PER_SECOND (MS_PER_SECOND)
  ) u_step (
    .cfg     (cfg),
    .item    (item),
    .st      (st),
    .st_next (st_next)
  );

  assign fire = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (fire) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.kind <= kind_t'(kind);
      item.wash_minutes <= wash_minutes;
      item.door_open <= door_open;
      item.water_full <= water_full;
      item.elapsed_ms <= elapsed_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Before the first completed fill, a write of the initial fill time also replaces the
  // learned fill time, unless the step logic updates the state in that same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.action <= ACT_NONE;
      st.timer <= '0;
      st.budget <= '0;
      st.learned <= INITIAL_FILL_SECONDS_RST;
      st.acc <= '0;
      st.relays <= '0;
      st.error <= 1'b0;
      st.fill_done <= 1'b0;
    end else if (fire) begin
      st <= st_next;
    end else if (cfg_we && cfg_index_t'(cfg_index) == CFG_INITIAL_FILL_SECONDS
                 && !st.fill_done) begin
      st.learned <= cfg_data;
    end
  end

  assign remaining_seconds = st.timer;
  assign active_action = st.action;
  assign soap_relay = st.relays[RLY_SOAP];
  assign valve_relay = st.relays[RLY_VALVE];
  assign wash_relay = st.relays[RLY_WASH];
  assign pump_relay = st.relays[RLY_PUMP];
  assign fill_error = st.error;

endmodule

`default_nettype wire

// ===== design/ats_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ats_cfg_regs
  import ats_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire cfg_index_t       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  output ats_cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.soap_seconds <= SOAP_SECONDS_RST;
      cfg.fill_max_seconds <= FILL_MAX_SECONDS_RST;
      cfg.empty_seconds <= EMPTY_SECONDS_RST;
      cfg.initial_fill_seconds <= INITIAL_FILL_SECONDS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SOAP_SECONDS: cfg.soap_seconds <= cfg_data;
        CFG_FILL_MAX_SECONDS: cfg.fill_max_seconds <= cfg_data;
        CFG_EMPTY_SECONDS: cfg.empty_seconds <= cfg_data;
        CFG_INITIAL_FILL_SECONDS: cfg.initial_fill_seconds <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/ats_step_logic.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ats_step_logic
  import ats_pkg::*;
#(
  parameter int unsigned MS_PER_SECOND = MS_PER_SECOND_DEFAULT
) (
  input  wire ats_cfg_t   cfg,
  input  wire ats_item_t  item,
  input  wire ats_state_t st,
  output ats_state_t      st_next
);

  localparam logic [ACC_W-1:0] MS_STEP = ACC_W'(MS_PER_SECOND);

  logic [ACC_W:0]     acc_sum;
  logic [ACC_W-1:0]   acc_sat;
  logic [TIMER_W-1:0] wash_secs;
  action_t            req;

  always_comb begin
    acc_sum = {1'b0, st.acc} + (ACC_W + 1)'(item.elapsed_ms);
    acc_sat = (acc_sum > {1'b0, ACC_MAX}) ? ACC_MAX : acc_sum[ACC_W-1:0];
    wash_secs = TIMER_W'(item.wash_minutes) * TIMER_W'(SECS_PER_MIN);

    unique case (item.kind)
      KIND_SOAP: req = ACT_SOAP;
      KIND_FILL: req = ACT_FILL;
      KIND_WASH: req = ACT_WASH;
      KIND_EMPTY: req = ACT_EMPTY;
      default: req = ACT_NONE;
    endcase

    st_next = st;
    st_next.acc = acc_sat;

    if (st.action == ACT_NONE) begin
      unique case (item.kind)
        KIND_SOAP: begin
          if (!item.door_open) begin
            st_next.action = ACT_SOAP;
            st_next.timer = TIMER_W'(cfg.soap_seconds);
            st_next.acc = '0;
            st_next.relays[RLY_SOAP] = 1'b1;
          end
        end
        KIND_FILL: begin
          st_next.budget = cfg.fill_max_seconds;
          st_next.error = 1'b0;
          st_next.action = ACT_FILL;
          st_next.timer = TIMER_W'(st.learned);
          st_next.acc = '0;
          st_next.relays[RLY_VALVE] = 1'b1;
        end
        KIND_WASH: begin
          st_next.action = ACT_WASH;
          st_next.timer = wash_secs;
          st_next.acc = '0;
          st_next.relays[RLY_WASH] = 1'b1;
        end
        default: begin
          st_next.action = ACT_EMPTY;
          st_next.timer = TIMER_W'(cfg.empty_seconds);
          st_next.acc = '0;
          st_next.relays[RLY_PUMP] = 1'b1;
        end
      endcase
    end else if (st.action == req && acc_sat >= MS_STEP) begin
      st_next.acc = acc_sat - MS_STEP;
      unique case (st.action)
        ACT_SOAP: begin
          if (st.timer != '0) begin
            st_next.timer = st.timer - 1'b1;
          end else begin
            st_next.relays[RLY_SOAP] = 1'b0;
            st_next.action = ACT_NONE;
          end
        end
        ACT_FILL: begin
          if (item.water_full) begin
            st_next.relays[RLY_VALVE] = 1'b0;
            st_next.action = ACT_NONE;
            st_next.timer = '0;
            st_next.learned = (cfg.fill_max_seconds >= st.budget) ?
                              (cfg.fill_max_seconds - st.budget) : '0;
            st_next.fill_done = 1'b1;
          end else if (st.timer != '0) begin
            st_next.timer = st.timer - 1'b1;
            if (st.budget != '0) begin
              st_next.budget = st.budget - 1'b1;
            end
          end else if (st.budget != '0) begin
            st_next.timer = TIMER_W'(st.budget);
          end else begin
            st_next.error = 1'b1;
            st_next.relays[RLY_VALVE] = 1'b0;
          end
        end
        ACT_WASH: begin
          if (st.timer != '0) begin
            if (item.door_open) begin
              st_next.relays[RLY_WASH] = 1'b0;
            end else begin
              st_next.relays[RLY_WASH] = 1'b1;
              st_next.timer = st.timer - 1'b1;
            end
          end else begin
            st_next.relays[RLY_WASH] = 1'b0;
            st_next.action = ACT_NONE;
          end
        end
        ACT_EMPTY: begin
          if (st.timer != '0) begin
            st_next.timer = st.timer - 1'b1;
          end else begin
            st_next.relays[RLY_PUMP] = 1'b0;
            st_next.action = ACT_NONE;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/ats_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "appliance_timed_action_sequencer_unit_defines.svh"

module ats_checker
  import ats_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [TIMER_W-1:0] remaining_seconds,
  input wire logic [2:0]         active_action,
  input wire logic               soap_relay,
  input wire logic               valve_relay,
  input wire logic               wash_relay,
  input wire logic               pump_relay,
  input wire logic               fill_error
);

  `ATS_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(remaining_seconds) && $stable(active_action), "stalled result changed")
  `ATS_ASSERT_NOW(a_idle_relays_off, out_valid && active_action == ACT_NONE, !soap_relay && !valve_relay && !wash_relay && !pump_relay, "relay on with no action")
  `ATS_ASSERT_NOW(a_error_valve_shut, out_valid && fill_error, !valve_relay, "valve open while fill error is flagged")
  `ATS_ASSERT_NOW(a_timer_range, out_valid, remaining_seconds <= 14'd15300, "timer beyond the longest action")

endmodule

bind appliance_timed_action_sequencer_unit ats_checker u_ats_checker (.*);

`default_nettype wire

// ===== verif/tb_appliance_timed_action_sequencer_unit.sv =====
`timescale 1ns / 1ps

module tb_appliance_timed_action_sequencer_unit;
  import ats_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HEAD_ROWS = 24;
  localparam int unsigned RANDOM_PER_PHASE = 250;

  typedef struct packed {
    logic [TIMER_W-1:0] secs;
    action_t act;
    logic [3:0] rly;
    logic err;
  } status_t;

  typedef struct {
    kind_t k;
    logic [7:0] mins;
    logic door;
    logic full;
    logic [15:0] el;
    logic typed;
    status_t want;
  } poll_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = '0;
  logic [7:0] wash_minutes = '0;
  logic door_open = 1'b0;
  logic water_full = 1'b0;
  logic [15:0] elapsed_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [TIMER_W-1:0] remaining_seconds;
  logic [2:0] active_action;
  logic soap_relay;
  logic valve_relay;
  logic wash_relay;
  logic pump_relay;
  logic fill_error;

  // Sequencer state as predicted from the accepted requests.
  logic [CFG_W-1:0] cfg_soap = SOAP_SECONDS_RST;
  logic [CFG_W-1:0] cfg_fill_max = FILL_MAX_SECONDS_RST;
  logic [CFG_W-1:0] cfg_empty = EMPTY_SECONDS_RST;
  logic [CFG_W-1:0] cfg_init = INITIAL_FILL_SECONDS_RST;
  action_t p_act = ACT_NONE;
  logic [TIMER_W-1:0] p_timer = '0;
  logic [CFG_W-1:0] p_budget = '0;
  logic [CFG_W-1:0] p_learned = INITIAL_FILL_SECONDS_RST;
  logic [ACC_W-1:0] p_acc = '0;
  logic [3:0] p_relays = '0;
  logic p_err = 1'b0;
  logic p_fill_done = 1'b0;

  status_t expected_status_q [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 21;
  int unsigned rx_idle_pct = 61;
  int phase_no = -1;
  int unsigned hold_left = 0;
  logic held = 1'b0;

  appliance_timed_action_sequencer_unit DUT (
    .clk,
    .rst,
    .cfg_we,
    .cfg_index,
    .cfg_data,
    .in_valid,
    .in_ready,
    .kind,
    .wash_minutes,
    .door_open,
    .water_full,
    .elapsed_ms,
    .out_valid,
    .out_ready,
    .remaining_seconds,
    .active_action,
    .soap_relay,
    .valve_relay,
    .wash_relay,
    .pump_relay,
    .fill_error
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // The receiver holds off once for a long stretch so that the block backs up.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (phase_no == 1 && !held) begin
      held <= 1'b1;
      hold_left <= 80;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic status_t status_of(int unsigned secs, action_t a, logic [3:0] rly,
                                        logic e);
    status_t s;
    s.secs = TIMER_W'(secs);
    s.act = a;
    s.rly = rly;
    s.err = e;
    return s;
  endfunction

  function automatic poll_row_t row(kind_t k, int unsigned mins, logic door, logic full,
                                    int unsigned el, logic typed, status_t want);
    poll_row_t r;
    r.k = k;
    r.mins = 8'(mins);
    r.door = door;
    r.full = full;
    r.el = 16'(el);
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic kind_t kind_for(action_t a);
    return kind_t'(2'(a - 3'd1));
  endfunction

  function automatic void apply_setting(cfg_index_t idx, logic [CFG_W-1:0] v);
    case (idx)
      CFG_SOAP_SECONDS: cfg_soap = v;
      CFG_FILL_MAX_SECONDS: cfg_fill_max = v;
      CFG_EMPTY_SECONDS: cfg_empty = v;
      default: begin
        cfg_init = v;
        if (!p_fill_done) p_learned = v;
      end
    endcase
  endfunction

  function automatic void launch(action_t a, logic [TIMER_W-1:0] secs, int unsigned bitpos);
    p_act = a;
    p_timer = secs;
    p_acc = '0;
    p_relays[bitpos] = 1'b1;
  endfunction

  function automatic status_t advance_sequencer(kind_t k, logic [7:0] mins, logic door,
                                                logic full, logic [15:0] el);
    logic [ACC_W:0] sum;
    sum = {1'b0, p_acc} + el;
    p_acc = (sum > ACC_MAX) ? ACC_MAX : sum[ACC_W-1:0];
    if (p_act == ACT_NONE) begin
      case (k)
        KIND_SOAP: if (!door) launch(ACT_SOAP, TIMER_W'(cfg_soap), RLY_SOAP);
        KIND_FILL: begin
          p_budget = cfg_fill_max;
          p_err = 1'b0;
          launch(ACT_FILL, TIMER_W'(p_learned), RLY_VALVE);
        end
        KIND_WASH: launch(ACT_WASH, TIMER_W'(mins * SECS_PER_MIN), RLY_WASH);
        default: launch(ACT_EMPTY, TIMER_W'(cfg_empty), RLY_PUMP);
      endcase
    end else if (kind_for(p_act) == k && p_acc >= MS_PER_SECOND_DEFAULT) begin
      p_acc = p_acc - ACC_W'(MS_PER_SECOND_DEFAULT);
      case (p_act)
        ACT_FILL: begin
          if (full) begin
            p_relays[RLY_VALVE] = 1'b0;
            p_act = ACT_NONE;
            p_timer = '0;
            p_learned = (cfg_fill_max >= p_budget) ? cfg_fill_max - p_budget : '0;
            p_fill_done = 1'b1;
          end else if (p_timer != 0) begin
            p_timer = p_timer - 1;
            if (p_budget != 0) p_budget = p_budget - 1;
          end else if (p_budget != 0) begin
            p_timer = TIMER_W'(p_budget);
          end else begin
            p_err = 1'b1;
            p_relays[RLY_VALVE] = 1'b0;
          end
        end
        ACT_WASH: begin
          if (p_timer != 0) begin
            if (door) begin
              p_relays[RLY_WASH] = 1'b0;
            end else begin
              p_relays[RLY_WASH] = 1'b1;
              p_timer = p_timer - 1;
            end
          end else begin
            p_relays[RLY_WASH] = 1'b0;
            p_act = ACT_NONE;
          end
        end
        default: begin
          if (p_timer != 0) begin
            p_timer = p_timer - 1;
          end else begin
            p_relays[(p_act == ACT_SOAP) ? RLY_SOAP : RLY_PUMP] = 1'b0;
            p_act = ACT_NONE;
          end
        end
      endcase
    end
    return status_of(p_timer, p_act, p_relays, p_err);
  endfunction

  task automatic send_poll(kind_t k, logic [7:0] mins, logic door, logic full,
                           logic [15:0] el, logic typed, status_t want);
    status_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    wash_minutes <= mins;
    door_open <= door;
    water_full <= full;
    elapsed_ms <= el;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = advance_sequencer(k, mins, door, full, el);
    expected_status_q.push_back(typed ? want : predicted);
  endtask

  task automatic write_settings(logic [CFG_W-1:0] soap, logic [CFG_W-1:0] fill_max,
                                logic [CFG_W-1:0] empty, logic [CFG_W-1:0] init_fill);
    logic [CFG_W-1:0] vals [4];
    cfg_index_t idx;
    in_valid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    vals = '{soap, fill_max, empty, init_fill};
    for (int n = 0; n < 4; n++) begin
      idx = cfg_index_t'(n);
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= vals[n];
      @(posedge clk);
      apply_setting(idx, vals[n]);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly requests for the running action with about a second elapsed, so that
  // timers run out and fills complete; the rest are stray requests and odd timings.
  task automatic run_random(int unsigned count, logic long_only);
    kind_t k;
    logic [7:0] mins;
    logic door;
    logic full;
    logic [15:0] el;
    for (int unsigned n = 0; n < count; n++) begin
      if (p_act == ACT_NONE) begin
        if (long_only) k = $urandom_range(1) ? KIND_WASH : KIND_FILL;
        else k = kind_t'($urandom_range(3));
        mins = 8'($urandom_range(3));
      end else begin
        if ($urandom_range(99) < 85) k = kind_for(p_act);
        else k = kind_t'($urandom_range(3));
        mins = 8'($urandom_range(255));
      end
      door = ($urandom_range(99) < 25);
      full = (p_act == ACT_FILL) ? ($urandom_range(99) < 15) : 1'($urandom_range(1));
      case ($urandom_range(9))
        0: el = '0;
        1: el = '1;
        2, 3: el = 16'($urandom_range(65535));
        default: el = 16'($urandom_range(900, 1100));
      endcase
      send_poll(k, mins, door, full, el, 1'b0, '0);
    end
  endtask

  task automatic cmp(string fld, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, fld, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    status_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_status_q.size() == 0) begin
        $display("%0t: result expected none, got timer %0d action %0d", $time,
                 remaining_seconds, active_action);
        mismatches++;
      end else begin
        want = expected_status_q.pop_front();
        cmp("remaining_seconds", want.secs, remaining_seconds);
        cmp("active_action", want.act, active_action);
        cmp("soap_relay", want.rly[RLY_SOAP], soap_relay);
        cmp("valve_relay", want.rly[RLY_VALVE], valve_relay);
        cmp("wash_relay", want.rly[RLY_WASH], wash_relay);
        cmp("pump_relay", want.rly[RLY_PUMP], pump_relay);
        cmp("fill_error", want.err, fill_error);
      end
    end
  end

  initial begin
    poll_row_t plan [$];
    poll_row_t r;

    // Directed requests, run with soap 2 s, fill limit 3 s, empty 1 s, initial fill 1 s.
    plan.push_back(row(KIND_SOAP, 0, 1, 0, 0, 1, status_of(0, ACT_NONE, 4'b0000, 0)));
    plan.push_back(row(KIND_SOAP, 0, 0, 0, 0, 1, status_of(2, ACT_SOAP, 4'b0001, 0)));
    plan.push_back(row(KIND_FILL, 0, 0, 0, 65535, 1, status_of(2, ACT_SOAP, 4'b0001, 0)));
    plan.push_back(row(KIND_SOAP, 0, 0, 0, 65535, 0, '0));
    plan.push_back(row(KIND_SOAP, 0, 0, 0, 65535, 0, '0));
    plan.push_back(row(KIND_SOAP, 0, 0, 0, 0, 1, status_of(0, ACT_NONE, 4'b0000, 0)));
    plan.push_back(row(KIND_FILL, 0, 0, 0, 0, 1, status_of(1, ACT_FILL, 4'b0010, 0)));
    plan.push_back(row(KIND_FILL, 0, 0, 0, 1000, 1, status_of(0, ACT_FILL, 4'b0010, 0)));
    plan.push_back(row(KIND_FILL, 0, 0, 0, 999, 1, status_of(0, ACT_FILL, 4'b0010, 0)));
    plan.push_back(row(KIND_FILL, 0, 0, 0, 1, 0, '0));
    plan.push_back(row(KIND_FILL, 0, 0, 0, 1000, 0, '0));
    plan.push_back(row(KIND_FILL, 0, 0, 0, 1000, 0, '0));
    plan.push_back(row(KIND_FILL, 0, 0, 0, 1000, 1, status_of(0, ACT_FILL, 4'b0000, 1)));
    plan.push_back(row(KIND_FILL, 0, 0, 1, 1000, 1, status_of(0, ACT_NONE, 4'b0000, 1)));
    plan.push_back(row(KIND_WASH, 0, 0, 0, 0, 1, status_of(0, ACT_WASH, 4'b0100, 1)));
    plan.push_back(row(KIND_WASH, 0, 1, 0, 1000, 1, status_of(0, ACT_NONE, 4'b0000, 1)));
    plan.push_back(row(KIND_EMPTY, 0, 0, 0, 0, 1, status_of(1, ACT_EMPTY, 4'b1000, 1)));
    plan.push_back(row(KIND_EMPTY, 0, 0, 0, 1000, 1, status_of(0, ACT_EMPTY, 4'b1000, 1)));
    plan.push_back(row(KIND_EMPTY, 0, 0, 0, 1000, 1, status_of(0, ACT_NONE, 4'b0000, 1)));
    plan.push_back(row(KIND_FILL, 0, 0, 1, 0, 1, status_of(3, ACT_FILL, 4'b0010, 0)));
    plan.push_back(row(KIND_FILL, 0, 0, 1, 1000, 1, status_of(0, ACT_NONE, 4'b0000, 0)));
    plan.push_back(row(KIND_WASH, 1, 0, 0, 0, 1, status_of(60, ACT_WASH, 4'b0100, 0)));
    plan.push_back(row(KIND_WASH, 0, 1, 0, 1000, 1, status_of(60, ACT_WASH, 4'b0000, 0)));
    plan.push_back(row(KIND_WASH, 0, 0, 0, 1000, 1, status_of(59, ACT_WASH, 4'b0100, 0)));
    // Closing requests: the longest wash, left running at the end of the run.
    plan.push_back(row(KIND_WASH, 255, 0, 0, 0, 0, '0));
    plan.push_back(row(KIND_SOAP, 255, 1, 1, 65535, 0, '0));
    plan.push_back(row(KIND_WASH, 0, 1, 0, 1000, 0, '0));
    plan.push_back(row(KIND_WASH, 0, 0, 0, 1000, 0, '0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    write_settings(12'd2, 12'd3, 12'd1, 12'd1);
    for (int unsigned n = 0; n < HEAD_ROWS; n++) begin
      r = plan[n];
      send_poll(r.k, r.mins, r.door, r.full, r.el, r.typed, r.want);
    end

    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        tx_idle_pct = 61;
        rx_idle_pct = 21;
      end else if (p == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (p)
        0: write_settings('0, '0, '0, '0);
        2: write_settings(12'd5, '1, 12'd3, 12'd7);
        default: write_settings(CFG_W'($urandom_range(6)), CFG_W'($urandom_range(20)),
                                CFG_W'($urandom_range(6)), CFG_W'($urandom_range(8)));
      endcase
      phase_no = p;
      run_random(RANDOM_PER_PHASE, 1'b0);
      // Leave a fill running on a large budget so that the next, lower limit
      // floors the learned time at zero.
      if (p == 2) begin
        while (p_act != ACT_FILL)
          send_poll((p_act == ACT_NONE) ? KIND_FILL : kind_for(p_act), '0, 1'b0, 1'b0,
                    16'd1000, 1'b0, '0);
      end
    end

    write_settings('1, '1, '1, '1);
    run_random(150, 1'b1);
    while (p_act != ACT_NONE)
      send_poll(kind_for(p_act), '0, 1'b0, 1'b1, 16'd1000, 1'b0, '0);
    for (int unsigned n = HEAD_ROWS; n < plan.size(); n++) begin
      r = plan[n];
      send_poll(r.k, r.mins, r.door, r.full, r.el, r.typed, r.want);
    end
    in_valid <= 1'b0;

    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_status_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
